// File: src/ffa_pkg.sv
// Shared constants and types of the first-fit heap allocator.
package ffa_pkg;

	localparam int unsigned HEAP_GRANULES_DEF = 4096;
	localparam int unsigned HEADER_BYTES_DEF  = 32;

	typedef logic [2:0] status_t;

	localparam status_t ST_ALLOC = 3'd0;
	localparam status_t ST_FREED = 3'd1;
	localparam status_t ST_NOMEM = 3'd2;
	localparam status_t ST_MISAL = 3'd3;
	localparam status_t ST_NOTAL = 3'd4;

	localparam logic FUNC_ALLOC = 1'b0;
	localparam logic FUNC_FREE  = 1'b1;

	localparam logic REG_REGION_START = 1'b0;
	localparam logic REG_REGION_END   = 1'b1;

endpackage

// File: src/ffa_req_if.sv
// Request channel carrying one allocate or free word.
interface ffa_req_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [31:0] alloc_size;
	logic [31:0] block_address;

	modport source (output valid, func, alloc_size, block_address, input ready);
	modport sink (input valid, func, alloc_size, block_address, output ready);
endinterface

// File: src/ffa_rsp_if.sv
// Response channel carrying one status word.
interface ffa_rsp_if import ffa_pkg::*;;
	logic        valid;
	logic        ready;
	status_t     status;
	logic [31:0] granted_address;

	modport source (output valid, status, granted_address, input ready);
	modport sink (input valid, status, granted_address, output ready);
endinterface

// File: src/ffa_ram.sv
// Generic simple dual-port RAM with a registered read.
module ffa_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// One write and one read per cycle.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: src/first_fit_heap_allocator_unit.sv
// First-fit heap allocator over a configured region of 16-byte granules. The block headers
// live in one RAM of HEAP_GRANULES entries with a registered read, and every allocate and
// every free that is not rejected walks that RAM one header per step. An allocate issues a
// read and then evaluates each block up to the first fit, writes the grant header and
// answers. A free reads the freed header and the one behind it, walks the blocks that lie
// in front of the freed one and writes the freed and merged headers; a rejected free answers
// early. After reset and after every register write all HEAP_GRANULES entries of the RAM are
// swept, during which no request word is taken. A response word may wait at the output while a new request is accepted.
module first_fit_heap_allocator_unit import ffa_pkg::*; #(
	parameter int unsigned HEAP_GRANULES = HEAP_GRANULES_DEF,
	parameter int unsigned HEADER_BYTES  = HEADER_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	ffa_req_if.sink     req,
	ffa_rsp_if.source   rsp,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);
	localparam int unsigned IW    = $clog2(HEAP_GRANULES);
	localparam int unsigned NW    = IW + 1;
	localparam int unsigned EW    = IW + 2;
	localparam int unsigned HDR_G = (HEADER_BYTES + 15) / 16;

	localparam logic [3:0] S_CLR   = 4'd0;
	localparam logic [3:0] S_IDLE  = 4'd1;
	localparam logic [3:0] A_ISS   = 4'd2;
	localparam logic [3:0] A_EVAL  = 4'd3;
	localparam logic [3:0] A_WG    = 4'd4;
	localparam logic [3:0] F_PRE   = 4'd5;
	localparam logic [3:0] F_CHK   = 4'd6;
	localparam logic [3:0] F_NX    = 4'd7;
	localparam logic [3:0] F_PISS  = 4'd8;
	localparam logic [3:0] F_PEVAL = 4'd9;
	localparam logic [3:0] F_END   = 4'd10;
	localparam logic [3:0] F_END2  = 4'd11;
	localparam logic [3:0] S_RESP  = 4'd12;

	logic [31:0]   start_q, end_q;
	logic [3:0]    state_q;
	logic [IW-1:0] cnt_q;
	logic [NW-1:0] g_q, p_q, nx_q;
	logic [28:0]   need_q;
	logic [31:0]   addr_q;
	logic [IW-1:0] gi_q, glen_q, new_len_q, prev_q, prev_len_q;
	logic          prev_used_q, has_prev_q;
	status_t       res_status_q;
	logic [31:0]   res_addr_q;
	logic          rsp_valid_q;
	status_t       rsp_status_q;
	logic [31:0]   rsp_addr_q;

	logic          cfg_wr;
	logic [32:0]   s_full, e_full, diff;
	logic [28:0]   n_raw;
	logic [NW-1:0] total;
	logic [31:0]   base32;

	logic          we;
	logic [IW-1:0] waddr, raddr;
	logic [EW-1:0] wdata, rdata;
	logic          rd_valid, rd_used;
	logic [IW-1:0] rd_len;

	// Free-address decode and walk arithmetic.
	logic [33:0]   lim, off_full;
	logic [NW-1:0] rd_next, p_next;
	logic          fit, split, merge;
	logic [IW-1:0] rem;

	// Configuration port.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = (paddr[2] == REG_REGION_END) ? end_q : start_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start_q <= 32'd0;
			end_q   <= 32'd65536;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_REGION_START) begin
				start_q <= pwdata;
			end else begin
				end_q <= pwdata;
			end
		end
	end

	// Region geometry from the registers.
	always_comb begin
		s_full = ({1'b0, start_q} + 33'd15) & ~33'hf;
		e_full = {1'b0, end_q & 32'hfffffff0};
		diff   = e_full - s_full;
		n_raw  = diff[32:4];
		total  = '0;
		if (e_full > s_full) begin
			if (n_raw > 29'(HEAP_GRANULES)) begin
				total = NW'(HEAP_GRANULES);
			end else begin
				total = n_raw[NW-1:0];
			end
		end
		if (total < NW'(HDR_G)) begin
			total = '0;
		end
	end
	assign base32 = s_full[31:0];

	ffa_ram #(.WIDTH(EW), .DEPTH(HEAP_GRANULES)) u_hdr_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	assign rd_valid = rdata[EW-1];
	assign rd_used  = rdata[EW-2];
	assign rd_len   = rdata[IW-1:0];

	always_comb begin
		lim      = {1'b0, s_full} + 34'(HDR_G * 16);
		off_full = (({2'b0, addr_q} - {1'b0, s_full}) >> 4) - 34'(HDR_G);
		rd_next  = g_q + NW'(HDR_G) + {1'b0, rd_len};
		p_next   = p_q + NW'(HDR_G) + {1'b0, rd_len};
		fit      = !rd_used && ({{(29 - IW){1'b0}}, rd_len} >= need_q);
		rem      = rd_len - need_q[IW-1:0];
		split    = rem >= IW'(HDR_G);
		merge    = has_prev_q && (p_q == {1'b0, gi_q}) && !prev_used_q;
	end

	// RAM access for each state.
	always_comb begin
		we    = 1'b0;
		waddr = '0;
		wdata = '0;
		raddr = '0;
		unique case (state_q)
			S_CLR: begin
				we    = 1'b1;
				waddr = cnt_q;
				if (cnt_q == '0 && total != '0) begin
					wdata = {2'b10, IW'(total - NW'(HDR_G))};
				end
			end
			A_ISS: begin
				raddr = g_q[IW-1:0];
			end
			A_EVAL: begin
				if (rd_valid && fit && split) begin
					we    = 1'b1;
					waddr = IW'(g_q + NW'(HDR_G) + {1'b0, need_q[IW-1:0]});
					wdata = {2'b10, IW'(rem - IW'(HDR_G))};
				end
			end
			A_WG: begin
				we    = 1'b1;
				waddr = g_q[IW-1:0];
				wdata = {2'b11, new_len_q};
			end
			F_PRE: begin
				raddr = off_full[IW-1:0];
			end
			F_CHK: begin
				raddr = IW'({1'b0, gi_q} + NW'(HDR_G) + {1'b0, rd_len});
			end
			F_NX: begin
				if (rd_valid && !rd_used) begin
					we    = 1'b1;
					waddr = nx_q[IW-1:0];
				end
			end
			F_PISS: begin
				raddr = p_q[IW-1:0];
			end
			F_END: begin
				we = 1'b1;
				if (merge) begin
					waddr = prev_q;
					wdata = {2'b10, IW'(prev_len_q + IW'(HDR_G) + glen_q)};
				end else begin
					waddr = gi_q;
					wdata = {2'b10, glen_q};
				end
			end
			F_END2: begin
				we    = 1'b1;
				waddr = gi_q;
			end
			default: begin
			end
		endcase
	end

	assign req.ready = (state_q == S_IDLE);

	// Sequencer; a register write rebuilds the heap.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			cnt_q   <= '0;
		end else if (cfg_wr) begin
			state_q <= S_CLR;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				S_CLR: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == IW'(HEAP_GRANULES - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (req.valid) begin
						addr_q     <= req.block_address;
						need_q     <= 29'(({1'b0, req.alloc_size} + 33'd15) >> 4);
						g_q        <= '0;
						res_addr_q <= '0;
						state_q    <= (req.func == FUNC_FREE) ? F_PRE : A_ISS;
					end
				end
				A_ISS: begin
					if (g_q >= total) begin
						res_status_q <= ST_NOMEM;
						state_q      <= S_RESP;
					end else begin
						state_q <= A_EVAL;
					end
				end
				A_EVAL: begin
					if (!rd_valid) begin
						res_status_q <= ST_NOMEM;
						state_q      <= S_RESP;
					end else if (fit) begin
						new_len_q    <= split ? need_q[IW-1:0] : rd_len;
						res_status_q <= ST_ALLOC;
						res_addr_q   <= base32 + (32'(g_q + NW'(HDR_G)) << 4);
						state_q      <= A_WG;
					end else begin
						g_q     <= rd_next;
						state_q <= A_ISS;
					end
				end
				A_WG: begin
					state_q <= S_RESP;
				end
				F_PRE: begin
					gi_q <= off_full[IW-1:0];
					if (addr_q[3:0] != 4'd0) begin
						res_status_q <= ST_MISAL;
						state_q      <= S_RESP;
					end else if ({2'b0, addr_q} < lim ||
							off_full >= {{(34 - NW){1'b0}}, total}) begin
						res_status_q <= ST_NOTAL;
						state_q      <= S_RESP;
					end else begin
						state_q <= F_CHK;
					end
				end
				F_CHK: begin
					p_q        <= '0;
					has_prev_q <= 1'b0;
					glen_q     <= rd_len;
					nx_q       <= {1'b0, gi_q} + NW'(HDR_G) + {1'b0, rd_len};
					if (!rd_valid || !rd_used) begin
						res_status_q <= ST_NOTAL;
						state_q      <= S_RESP;
					end else if (({1'b0, gi_q} + NW'(HDR_G) + {1'b0, rd_len}) < total) begin
						state_q <= F_NX;
					end else begin
						state_q <= F_PISS;
					end
				end
				F_NX: begin
					if (rd_valid && !rd_used) begin
						glen_q <= glen_q + IW'(HDR_G) + rd_len;
					end
					state_q <= F_PISS;
				end
				F_PISS: begin
					state_q <= (p_q < {1'b0, gi_q}) ? F_PEVAL : F_END;
				end
				F_PEVAL: begin
					if (!rd_valid) begin
						state_q <= F_END;
					end else begin
						prev_q      <= p_q[IW-1:0];
						prev_used_q <= rd_used;
						prev_len_q  <= rd_len;
						has_prev_q  <= 1'b1;
						p_q         <= p_next;
						state_q     <= F_PISS;
					end
				end
				F_END: begin
					res_status_q <= ST_FREED;
					state_q      <= merge ? F_END2 : S_RESP;
				end
				F_END2: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (!rsp_valid_q || rsp.ready) begin
						rsp_status_q <= res_status_q;
						rsp_addr_q   <= res_addr_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// The output word is raised when a result is handed over and dropped once taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_RESP && !cfg_wr && (!rsp_valid_q || rsp.ready)) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	assign rsp.valid           = rsp_valid_q;
	assign rsp.status          = rsp_status_q;
	assign rsp.granted_address = rsp_addr_q;

`ifndef SYNTHESIS
	// No request word is taken while the header RAM is being swept.
	a_no_req_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> !req.ready)
		else $error("request taken during clearing sweep");
	// Only a grant carries an address.
	a_addr_only_on_grant: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.status != ST_ALLOC |-> rsp.granted_address == 32'd0)
		else $error("address on a non-grant response");
	// An idle block leaves the header RAM alone.
	a_no_write_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !we)
		else $error("header write while idle");
`endif
endmodule

// File: tb/sv/first_fit_heap_allocator_unit_tb.sv
// Self-checking testbench of the first-fit heap allocator: directed table, then random traffic.
`timescale 1ns / 100ps

module first_fit_heap_allocator_unit_tb;
	import ffa_pkg::*;

	localparam int unsigned GRANULES   = HEAP_GRANULES_DEF;
	localparam int unsigned HDR_GRAN   = (HEADER_BYTES_DEF + 15) / 16;
	localparam longint     CYCLE_LIMIT = 20000000;
	localparam int unsigned DRAIN_WAIT = 64;

	// One row of the directed table; the expectation is only checked when chk is set.
	typedef struct {
		logic        func;
		logic [31:0] size;
		logic [31:0] addr;
		bit          chk;
		status_t     st;
		logic [31:0] ga;
	} dir_row_t;

	typedef struct {
		status_t     st;
		logic [31:0] ga;
	} heap_answer_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [2:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;

	ffa_req_if req ();
	ffa_rsp_if rsp ();

	first_fit_heap_allocator_unit dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (req.sink),
		.rsp     (rsp.source),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Mirror of the heap: header marks per granule, region base and size.
	bit              blk_start [GRANULES];
	bit              blk_taken [GRANULES];
	int unsigned     blk_len   [GRANULES];
	longint unsigned heap_first;
	int unsigned     heap_gran;
	logic [31:0]     cfg_start;
	logic [31:0]     cfg_end;

	heap_answer_t    pending_answers [$];
	logic [31:0]     live_blocks [$];
	logic [31:0]     freed_blocks [$];

	int unsigned     tx_idle_pct;
	int unsigned     rx_idle_pct;
	int unsigned     rx_hold_cycles;
	int unsigned     error_count;
	int unsigned     words_sent;
	int unsigned     words_checked;
	int unsigned     grants_seen;
	int unsigned     frees_seen;
	int unsigned     nomem_seen;
	longint          cycle_count;

	dir_row_t dir_rows [0:17] = '{
		'{FUNC_ALLOC, 32'd0,          32'd0,          1'b1, ST_ALLOC, 32'd32},
		'{FUNC_ALLOC, 32'hffffffff,   32'd0,          1'b1, ST_NOMEM, 32'd0},
		'{FUNC_FREE,  32'd0,          32'h00000003,   1'b1, ST_MISAL, 32'd0},
		'{FUNC_FREE,  32'd0,          32'h00000010,   1'b1, ST_NOTAL, 32'd0},
		'{FUNC_FREE,  32'd0,          32'd32,         1'b1, ST_FREED, 32'd0},
		'{FUNC_FREE,  32'd0,          32'd32,         1'b1, ST_NOTAL, 32'd0},
		'{FUNC_ALLOC, 32'd1,          32'd0,          1'b1, ST_ALLOC, 32'd32},
		'{FUNC_ALLOC, 32'd16,         32'd0,          1'b0, ST_ALLOC, 32'd0},
		'{FUNC_FREE,  32'd0,          32'd48,         1'b1, ST_NOTAL, 32'd0},
		'{FUNC_FREE,  32'd0,          32'hfffffff0,   1'b1, ST_NOTAL, 32'd0},
		'{FUNC_FREE,  32'hffffffff,   32'hffffffff,   1'b1, ST_MISAL, 32'd0},
		'{FUNC_ALLOC, 32'd65536,      32'd0,          1'b1, ST_NOMEM, 32'd0},
		'{FUNC_ALLOC, 32'd65392,      32'd0,          1'b0, ST_ALLOC, 32'd0},
		'{FUNC_ALLOC, 32'd0,          32'd0,          1'b1, ST_NOMEM, 32'd0},
		'{FUNC_FREE,  32'd0,          32'd80,         1'b0, ST_FREED, 32'd0},
		'{FUNC_FREE,  32'd0,          32'd32,         1'b0, ST_FREED, 32'd0},
		'{FUNC_FREE,  32'd0,          32'd128,        1'b0, ST_FREED, 32'd0},
		'{FUNC_ALLOC, 32'd65504,      32'd0,          1'b1, ST_ALLOC, 32'd32}
	};

	// Clock: 10 ns period.
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// Rebuild the mirror heap as one free block over the configured region.
	function automatic void heap_rebuild();
		longint unsigned s;
		longint unsigned e;
		longint unsigned n;
		s = ({32'd0, cfg_start} + 64'd15) & ~64'd15;
		e = {32'd0, cfg_end & 32'hfffffff0};
		for (int i = 0; i < GRANULES; i++) begin
			blk_start[i] = 1'b0;
			blk_taken[i] = 1'b0;
			blk_len[i]   = 0;
		end
		heap_first = s;
		heap_gran  = 0;
		if (e > s) begin
			n = (e - s) >> 4;
			if (n > GRANULES)
				n = GRANULES;
			heap_gran = int'(n);
		end
		if (heap_gran >= HDR_GRAN && heap_gran > 0) begin
			blk_start[0] = 1'b1;
			blk_len[0]   = heap_gran - HDR_GRAN;
		end else begin
			heap_gran = 0;
		end
	endfunction

	// First fit: walk the chain, split when the remainder holds a header.
	function automatic heap_answer_t heap_allocate(logic [31:0] size);
		heap_answer_t    ans;
		longint unsigned want;
		int unsigned     g;
		int unsigned     r;
		want = ({32'd0, size} + 64'd15) >> 4;
		g = 0;
		ans.st = ST_NOMEM;
		ans.ga = '0;
		while (g < heap_gran && blk_start[g]) begin
			if (!blk_taken[g] && longint'(blk_len[g]) >= want) begin
				if (blk_len[g] - int'(want) >= HDR_GRAN) begin
					r = g + HDR_GRAN + int'(want);
					blk_start[r] = 1'b1;
					blk_taken[r] = 1'b0;
					blk_len[r]   = blk_len[g] - int'(want) - HDR_GRAN;
					blk_len[g]   = int'(want);
				end
				blk_taken[g] = 1'b1;
				ans.st = ST_ALLOC;
				ans.ga = 32'(heap_first + (longint'(g) + HDR_GRAN) * 16);
				return ans;
			end
			g = g + HDR_GRAN + blk_len[g];
		end
		return ans;
	endfunction

	// Release a block and merge it with free neighbours on both sides.
	function automatic heap_answer_t heap_release(logic [31:0] addr);
		heap_answer_t    ans;
		longint unsigned a;
		longint unsigned off;
		int unsigned     g;
		int unsigned     nx;
		int unsigned     p;
		int unsigned     prev;
		bit              has_prev;
		ans.ga = '0;
		a = {32'd0, addr};
		has_prev = 1'b0;
		if (addr[3:0] != 4'd0) begin
			ans.st = ST_MISAL;
			return ans;
		end
		if (a < heap_first + HDR_GRAN * 16) begin
			ans.st = ST_NOTAL;
			return ans;
		end
		off = ((a - heap_first) >> 4) - HDR_GRAN;
		if (off >= heap_gran || !blk_start[off] || !blk_taken[off]) begin
			ans.st = ST_NOTAL;
			return ans;
		end
		g = int'(off);
		blk_taken[g] = 1'b0;
		nx = g + HDR_GRAN + blk_len[g];
		if (nx < heap_gran && blk_start[nx] && !blk_taken[nx]) begin
			blk_len[g]    += HDR_GRAN + blk_len[nx];
			blk_start[nx] = 1'b0;
			blk_len[nx]   = 0;
		end
		prev = 0;
		p = 0;
		while (p < g && blk_start[p]) begin
			prev = p;
			has_prev = 1'b1;
			p = p + HDR_GRAN + blk_len[p];
		end
		if (has_prev && p == g && !blk_taken[prev]) begin
			blk_len[prev] += HDR_GRAN + blk_len[g];
			blk_start[g]  = 1'b0;
			blk_len[g]    = 0;
		end
		ans.st = ST_FREED;
		return ans;
	endfunction

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at %0t: %s got %0h, expected %0h", $time, what, got, want);
		error_count++;
	endtask

	// Offer one request word, with random idle cycles in front of it.
	task automatic send_word(logic func, logic [31:0] size, logic [31:0] addr,
			bit chk, status_t st, logic [31:0] ga);
		heap_answer_t ans;
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			req.valid <= 1'b0;
			@(posedge clk);
		end
		req.valid         <= 1'b1;
		req.func          <= func;
		req.alloc_size    <= size;
		req.block_address <= addr;
		do
			@(posedge clk);
		while (!req.ready);
		// Accepted at this edge: predict in order of acceptance.
		if (func == FUNC_ALLOC)
			ans = heap_allocate(size);
		else
			ans = heap_release(addr);
		if (chk && (ans.st != st || ans.ga != ga))
			report_mismatch("table row", {29'd0, st}, {29'd0, ans.st});
		if (ans.st == ST_ALLOC)
			live_blocks.push_back(ans.ga);
		if (ans.st == ST_FREED)
			freed_blocks.push_back(addr);
		pending_answers.push_back(ans);
		words_sent++;
	endtask

	// Mostly well-formed allocate and free traffic, some noise.
	task automatic random_words(int unsigned count);
		logic [31:0] size;
		logic [31:0] addr;
		int unsigned k;
		int unsigned pick;
		repeat (count) begin
			pick = $urandom_range(0, 99);
			size = $urandom();
			addr = $urandom();
			if (pick < 55) begin
				k = $urandom_range(0, 99);
				if (k < 70)
					size = $urandom_range(0, 512);
				else if (k < 95)
					size = $urandom_range(0, 8192);
				send_word(FUNC_ALLOC, size, addr, 1'b0, ST_ALLOC, '0);
			end else if (pick < 90 && live_blocks.size() > 0) begin
				k = $urandom_range(0, live_blocks.size() - 1);
				addr = live_blocks[k];
				live_blocks.delete(k);
				send_word(FUNC_FREE, size, addr, 1'b0, ST_FREED, '0);
			end else if (pick < 94 && freed_blocks.size() > 0) begin
				addr = freed_blocks[$urandom_range(0, freed_blocks.size() - 1)];
				send_word(FUNC_FREE, size, addr, 1'b0, ST_FREED, '0);
			end else begin
				send_word($urandom_range(0, 1), size, addr, 1'b0, ST_FREED, '0);
			end
		end
		req.valid <= 1'b0;
	endtask

	// Register write over the configuration port, followed by a read back.
	task automatic write_register(logic index, logic [31:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {index, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata != value)
			report_mismatch("register read back", prdata, value);
		psel    <= 1'b0;
		penable <= 1'b0;
		if (index == REG_REGION_START)
			cfg_start = value;
		else
			cfg_end = value;
		heap_rebuild();
		live_blocks.delete();
		freed_blocks.delete();
	endtask

	// Wait until every expected word has come back, then let the block settle.
	task automatic drain();
		while (pending_answers.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic new_region(logic [31:0] first, logic [31:0] last);
		write_register(REG_REGION_START, first);
		write_register(REG_REGION_END, last);
	endtask

	// Receiver: random back-pressure, or a long hold-off when one is requested.
	always @(posedge clk) begin
		if (rx_hold_cycles > 0) begin
			rsp.ready      <= 1'b0;
			rx_hold_cycles <= rx_hold_cycles - 1;
		end else begin
			rsp.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	// Response checker against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && rsp.valid && rsp.ready) begin
			if (pending_answers.size() == 0) begin
				report_mismatch("unexpected word, status", {29'd0, rsp.status}, '0);
			end else begin
				if (rsp.status != pending_answers[0].st)
					report_mismatch("status", {29'd0, rsp.status},
						{29'd0, pending_answers[0].st});
				if (rsp.granted_address != pending_answers[0].ga)
					report_mismatch("granted address", rsp.granted_address,
						pending_answers[0].ga);
				case (pending_answers[0].st)
					ST_ALLOC: grants_seen++;
					ST_FREED: frees_seen++;
					ST_NOMEM: nomem_seen++;
					default: ;
				endcase
				void'(pending_answers.pop_front());
				words_checked++;
			end
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Main sequence.
	initial begin
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		req.valid         = 1'b0;
		req.func          = FUNC_ALLOC;
		req.alloc_size    = '0;
		req.block_address = '0;
		rsp.ready         = 1'b0;
		rx_hold_cycles    = 0;
		tx_idle_pct       = 16;
		rx_idle_pct       = 52;
		error_count       = 0;
		words_sent        = 0;
		words_checked     = 0;
		grants_seen       = 0;
		frees_seen        = 0;
		nomem_seen        = 0;
		cycle_count       = 0;
		cfg_start         = 32'd0;
		cfg_end           = 32'd65536;
		heap_rebuild();
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table on the region left by reset.
		foreach (dir_rows[i])
			send_word(dir_rows[i].func, dir_rows[i].size, dir_rows[i].addr,
				dir_rows[i].chk, dir_rows[i].st, dir_rows[i].ga);
		req.valid <= 1'b0;
		random_words(120);
		drain();

		// Unaligned region, with one long receiver hold-off while requests keep coming.
		new_region(32'h12345677, 32'h1234b677);
		fork
			random_words(60);
			begin
				repeat (20) @(posedge clk);
				rx_hold_cycles <= 400;
			end
		join
		random_words(60);
		drain();

		// Region too large: only the first granules are managed.
		tx_idle_pct = 52;
		rx_idle_pct = 16;
		new_region(32'h00000000, 32'hffffffff);
		random_words(140);
		drain();

		// Degenerate regions: header only, too small, reversed, and past the top.
		new_region(32'h00000100, 32'h00000120);
		random_words(6);
		drain();
		new_region(32'h00000100, 32'h00000110);
		random_words(6);
		drain();
		new_region(32'h00008000, 32'h00000100);
		random_words(6);
		drain();
		new_region(32'hffffffff, 32'hffffffff);
		random_words(6);
		drain();

		// Region at the very top of the address space, with no idling.
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		new_region(32'hffff8001, 32'hffffffff);
		random_words(160);
		drain();
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("%0d request words sent, %0d answers checked over eight regions.",
			words_sent, words_checked);
		$display("%0d grants, %0d frees, %0d out of memory.",
			grants_seen, frees_seen, nomem_seen);
		if (error_count == 0 && pending_answers.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
